// File: sv/bubble_sort_engine_top_assert.svh
// Assertion macros shared by the sorter checker
`ifndef BUBBLE_SORT_ENGINE_TOP_ASSERT_SVH
`define BUBBLE_SORT_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define BSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define BSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/bse_pkg.sv
// Package for the bubble sort engine: widths, defaults and controller states
`timescale 1ns / 1ps

package bse_pkg;

	localparam int VALUE_W   = 32;
	localparam int DEPTH_DEF = 64;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PASS_START,
		ST_PASS_FIRST,
		ST_PASS_RUN,
		ST_PASS_END,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_HOLD
	} state_t;

endpackage

// File: sv/bse_if.sv
// Stream interfaces: list element input and sorted result output
`timescale 1ns / 1ps

interface bse_in_if;
	import bse_pkg::*;

	logic   valid;
	logic   ready;
	value_t value;
	logic   last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

interface bse_out_if;
	import bse_pkg::*;

	logic   valid;
	logic   ready;
	value_t value_res;
	logic   last_res;
	logic   overflow;

	modport source (output valid, output value_res, output last_res, output overflow,
		input ready);
	modport sink   (input valid, input value_res, input last_res, input overflow,
		output ready);
endinterface

// File: sv/bse_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module bse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/bubble_sort_engine_top.sv
// Top level of the bubble sort engine: load, in-memory sort and emit controller
`timescale 1ns / 1ps

// Bubble sort engine. Words arrive on items one per cycle and are written to
// a single RAM in arrival order; the word with last set closes the list (words
// past DEPTH are dropped and the whole list is flagged with overflow). The list
// is then sorted ascending in place. Each pass streams the unsorted range out
// of the RAM's one read port, carrying the larger value forward and writing
// the smaller back one slot behind the read pointer; at most n - 1 passes run
// for n words, and the sort ends early after a pass with no exchange. Sorted
// words then leave on results, each read from the RAM and then loaded into
// the output register. No new word is taken until the last result of the
// current list has been accepted.
module bubble_sort_engine_top #(
	parameter int DEPTH = bse_pkg::DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bse_in_if.sink       items,
	bse_out_if.source    results
);
	import bse_pkg::*;

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

	// controller state
	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;        // words stored in the current list
	logic             ovf_q, ovf_d;        // a word of this list was dropped
	logic [CNT_W-1:0] range_q, range_d;    // unsorted range of the current pass
	logic [CNT_W-1:0] idx_q, idx_d;        // data index in a pass, word index on emit
	logic             swapped_q, swapped_d;
	value_t           left_q, left_d;      // running maximum carried along a pass

	// output register
	logic             out_valid_q, out_valid_d;
	value_t           out_value_q, out_value_d;
	logic             out_last_q, out_last_d;
	logic             out_ovf_q, out_ovf_d;

	// RAM port
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [VALUE_W-1:0] ram_wdata, ram_rdata;
	value_t            rd_value;

	logic              full;
	logic [CNT_W-1:0]  cnt_after;
	logic              greater;

	assign rd_value  = $signed(ram_rdata);
	assign full      = (cnt_q == CNT_FULL);
	assign cnt_after = full ? cnt_q : cnt_q + CNT_ONE;
	assign greater   = (left_q > rd_value);

	bse_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			range_q     <= '0;
			idx_q       <= '0;
			swapped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			ovf_q       <= ovf_d;
			range_q     <= range_d;
			idx_q       <= idx_d;
			swapped_q   <= swapped_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		left_q      <= left_d;
		out_value_q <= out_value_d;
		out_last_q  <= out_last_d;
		out_ovf_q   <= out_ovf_d;
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		ovf_d       = ovf_q;
		range_d     = range_q;
		idx_d       = idx_q;
		swapped_d   = swapped_q;
		left_d      = left_q;
		out_valid_d = out_valid_q;
		out_value_d = out_value_q;
		out_last_d  = out_last_q;
		out_ovf_d   = out_ovf_q;
		ram_we      = 1'b0;
		ram_waddr   = '0;
		ram_wdata   = '0;
		ram_re      = 1'b0;
		ram_raddr   = '0;
		items.ready = 1'b0;

		unique case (state_q)
			ST_LOAD: begin
				// ready is always high here, so valid alone marks a taken word
				items.ready = 1'b1;
				if (items.valid) begin
					if (!full) begin
						ram_we    = 1'b1;
						ram_waddr = cnt_q[ADDR_W-1:0];
						ram_wdata = items.value;
					end else begin
						ovf_d = 1'b1;
					end
					cnt_d = cnt_after;
					if (items.last) begin
						range_d = cnt_after;
						idx_d   = '0;
						// a single word is already sorted
						state_d = (cnt_after > CNT_ONE) ? ST_PASS_START : ST_EMIT_RD;
					end
				end
			end

			ST_PASS_START: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
				swapped_d = 1'b0;
				state_d   = ST_PASS_FIRST;
			end

			ST_PASS_FIRST: begin
				left_d    = rd_value;
				ram_re    = 1'b1;
				ram_raddr = ADDR_W'(1);
				idx_d     = CNT_ONE;
				state_d   = ST_PASS_RUN;
			end

			ST_PASS_RUN: begin
				// smaller of the pair settles one slot behind, larger moves on
				ram_we    = 1'b1;
				ram_waddr = ADDR_W'(idx_q - CNT_ONE);
				ram_wdata = greater ? rd_value : left_q;
				left_d    = greater ? left_q : rd_value;
				if (greater) begin
					swapped_d = 1'b1;
				end
				if (idx_q == range_q - CNT_ONE) begin
					state_d = ST_PASS_END;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = ADDR_W'(idx_q + CNT_ONE);
					idx_d     = idx_q + CNT_ONE;
				end
			end

			ST_PASS_END: begin
				ram_we    = 1'b1;
				ram_waddr = ADDR_W'(range_q - CNT_ONE);
				ram_wdata = left_q;
				range_d   = range_q - CNT_ONE;
				if (!swapped_q || range_q <= CNT_TWO) begin
					idx_d   = '0;
					state_d = ST_EMIT_RD;
				end else begin
					state_d = ST_PASS_START;
				end
			end

			ST_EMIT_RD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q[ADDR_W-1:0];
				state_d   = ST_EMIT_LD;
			end

			ST_EMIT_LD: begin
				out_valid_d = 1'b1;
				out_value_d = rd_value;
				out_last_d  = (idx_q == cnt_q - CNT_ONE);
				out_ovf_d   = ovf_q;
				state_d     = ST_EMIT_HOLD;
			end

			ST_EMIT_HOLD: begin
				if (results.ready) begin
					out_valid_d = 1'b0;
					if (out_last_q) begin
						cnt_d   = '0;
						ovf_d   = 1'b0;
						state_d = ST_LOAD;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = ADDR_W'(idx_q + CNT_ONE);
						idx_d     = idx_q + CNT_ONE;
						state_d   = ST_EMIT_LD;
					end
				end
			end

			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	assign results.valid     = out_valid_q;
	assign results.value_res = out_value_q;
	assign results.last_res  = out_last_q;
	assign results.overflow  = out_ovf_q;

endmodule

// File: sv/bse_checker.sv
// Port-level checker for the bubble sort engine, bound to the top level
`timescale 1ns / 1ps

`include "bubble_sort_engine_top_assert.svh"

module bse_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  in_last,
	input logic                  out_valid,
	input logic                  out_ready,
	input bse_pkg::value_t       out_value_res,
	input logic                  out_last_res,
	input logic                  out_overflow
);
	import bse_pkg::*;

	// loading and emitting never overlap
	`BSE_ASSERT_NOW(a_no_load_while_emit, out_valid, !in_ready, "input ready while word pending")

	// a closed list stops the input until its results are out
	`BSE_ASSERT_NEXT(a_close_stalls_input, in_valid && in_ready && in_last, !in_ready, "input ready after close")

	// after the final result the output goes quiet
	`BSE_ASSERT_NEXT(a_last_ends_run, out_valid && out_ready && out_last_res, !out_valid, "result after last")

	// a stalled result holds its word
	`BSE_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_value_res) && $stable(out_last_res) && $stable(out_overflow), "stalled result changed")

endmodule

bind bubble_sort_engine_top bse_checker u_bse_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (items.valid),
	.in_ready      (items.ready),
	.in_last       (items.last),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.out_value_res (results.value_res),
	.out_last_res  (results.last_res),
	.out_overflow  (results.overflow)
);
